// ===== design/m7aa_pkg.sv =====
// Package with the item types, field widths and power-of-two helpers of the Magic7 adjust block.
`timescale 1ns / 1ps

package m7aa_pkg;

    localparam int ALPHA_W = 16;
    localparam int REG_W   = 3;
    localparam int ADJ_W   = 19;
    // Widest internal value: FRAC_BITS up to 24 plus three bits for sevenths.
    localparam int WORD_W  = 32;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_num;
        logic [REG_W-1:0]   regularity;
    } t_in_item;

    typedef struct packed {
        logic [ADJ_W-1:0] adjusted_num;
    } t_out_item;

    // Largest power of two at or below v, zero when v is zero.
    function automatic t_word pow2_floor(input t_word v);
        t_word p;
        p = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                p = t_word'(1) << i;
            end
        end
        return p;
    endfunction

    // Smallest power of two at or above v, for v of at least one.
    function automatic t_word pow2_ceil(input t_word v);
        t_word f;
        f = pow2_floor(v);
        if (f == v) begin
            return f;
        end
        return f << 1;
    endfunction

endpackage

// ===== design/m7aa_stream_if.sv =====
// Valid/ready stream interface that carries one item of a given payload type.
`timescale 1ns / 1ps

interface m7aa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/magic7_availability_adjust.sv =====
// Magic7 adjusted availability factor: clamp stage, one stage per level, output stage.
//
// Usage: an input item carries alpha_num (alpha as a fraction of 2^FRAC_BITS)
// and regularity k. Each item yields exactly one result item, adjusted_num,
// the adjusted factor as a numerator over 7*2^FRAC_BITS.
// Both channels use valid/ready; an item moves when valid and ready are high
// at a rising clock edge.
// There are MAX_K + 1 register stages: the clamp stage loaded at the accepting
// edge, MAX_K - 1 level stages (each one leading-one detect, subtract and add)
// and the rounding stage that holds the result item.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, every stage holds and input ready drops until the
// result register is taken, so no item is lost or repeated.
// Synchronous reset (i_rst_n low) clears all stage valid bits; the pipeline
// is empty and accepts an item in the first cycle after reset.
`timescale 1ns / 1ps

module magic7_availability_adjust #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_K     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    m7aa_stream_if.sink          i_in,
    m7aa_stream_if.source        o_out
);
    import m7aa_pkg::*;

    localparam int VW = FRAC_BITS + 3;
    localparam int KW = $clog2(MAX_K + 1);

    logic          en;
    logic          w_valid [MAX_K];
    logic [VW-1:0] w_v     [MAX_K];
    logic [VW-1:0] w_acc   [MAX_K];
    logic [KW-1:0] w_k     [MAX_K];
    logic          out_valid;
    logic [ADJ_W-1:0] out_adj;

    // The whole pipeline advances whenever the result register is free or taken.
    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    m7aa_prep #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_K     (MAX_K),
        .VW        (VW),
        .KW        (KW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_alpha (i_in.data.alpha_num),
        .i_k     (i_in.data.regularity),
        .o_valid (w_valid[0]),
        .o_v     (w_v[0]),
        .o_k     (w_k[0])
    );
    assign w_acc[0] = '0;

    for (genvar j = 1; j < MAX_K; j++) begin : g_level
        m7aa_level #(
            .FRAC_BITS (FRAC_BITS),
            .MAX_K     (MAX_K),
            .LEVEL     (j),
            .VW        (VW),
            .KW        (KW)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[j-1]),
            .i_v     (w_v[j-1]),
            .i_acc   (w_acc[j-1]),
            .i_k     (w_k[j-1]),
            .o_valid (w_valid[j]),
            .o_v     (w_v[j]),
            .o_acc   (w_acc[j]),
            .o_k     (w_k[j])
        );
    end

    m7aa_final #(
        .FRAC_BITS (FRAC_BITS),
        .VW        (VW)
    ) u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[MAX_K-1]),
        .i_v     (w_v[MAX_K-1]),
        .i_acc   (w_acc[MAX_K-1]),
        .o_valid (out_valid),
        .o_adj   (out_adj)
    );

    assign o_out.valid             = out_valid;
    assign o_out.data.adjusted_num = out_adj;

endmodule

// ===== design/m7aa_prep.sv =====
// First pipeline stage: clamps the inputs and scales alpha to units of one seventh.
`timescale 1ns / 1ps

module m7aa_prep #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_K     = 4,
    parameter int VW        = FRAC_BITS + 3,
    parameter int KW        = $clog2(MAX_K + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [m7aa_pkg::ALPHA_W-1:0]  i_alpha,
    input  logic [m7aa_pkg::REG_W-1:0]    i_k,
    output logic                          o_valid,
    output logic [VW-1:0]                 o_v,
    output logic [KW-1:0]                 o_k
);
    import m7aa_pkg::*;

    localparam int CW = (REG_W > KW ? REG_W : KW) + 1;

    logic [FRAC_BITS-1:0] a;
    logic [CW-1:0]        k_wide;
    logic [KW-1:0]        n_k;
    logic [VW-1:0]        n_v;
    logic                 r_valid;
    logic [VW-1:0]        r_v;
    logic [KW-1:0]        r_k;

    always_comb begin
        if ((i_alpha >> FRAC_BITS) != '0) begin
            a = '1;
        end else begin
            a = FRAC_BITS'(i_alpha);
        end
        n_v = (VW'(a) << 3) - VW'(a);

        k_wide = CW'(i_k);
        if (k_wide == '0) begin
            k_wide = CW'(1);
        end else if (k_wide > CW'(MAX_K)) begin
            k_wide = CW'(MAX_K);
        end
        n_k = KW'(k_wide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_k <= n_k;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_k     = r_k;

endmodule

// ===== design/m7aa_level.sv =====
// One approximation level: adds the Magic7 value below the residual and keeps the rest.
`timescale 1ns / 1ps

module m7aa_level #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_K     = 4,
    parameter int LEVEL     = 1,
    parameter int VW        = FRAC_BITS + 3,
    parameter int KW        = $clog2(MAX_K + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [VW-1:0] i_v,
    input  logic [VW-1:0] i_acc,
    input  logic [KW-1:0] i_k,
    output logic          o_valid,
    output logic [VW-1:0] o_v,
    output logic [VW-1:0] o_acc,
    output logic [KW-1:0] o_k
);
    import m7aa_pkg::*;

    localparam logic [VW-1:0] SEVENTH = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] ONE_U   = SEVENTH * VW'(7);
    localparam logic [VW-1:0] SIX_S   = SEVENTH * VW'(6);

    logic [VW-1:0] down;
    logic [VW-1:0] n_v;
    logic [VW-1:0] n_acc;
    logic          r_valid;
    logic [VW-1:0] r_v;
    logic [VW-1:0] r_acc;
    logic [KW-1:0] r_k;

    always_comb begin
        if (i_v < SEVENTH) begin
            // Zero falls in here and yields zero.
            down = VW'(pow2_floor(t_word'(i_v)));
        end else if (i_v <= SIX_S) begin
            down = i_v & ~(SEVENTH - VW'(1));
        end else begin
            down = ONE_U - VW'(pow2_ceil(t_word'(ONE_U - i_v)));
        end

        // This level takes part only while regularity k is above LEVEL.
        if ((KW + 1)'(i_k) > (KW + 1)'(LEVEL)) begin
            n_v   = i_v - down;
            n_acc = i_acc + down;
        end else begin
            n_v   = i_v;
            n_acc = i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_acc <= n_acc;
            r_k   <= i_k;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_acc   = r_acc;
    assign o_k     = r_k;

endmodule

// ===== design/m7aa_final.sv =====
// Last stage: rounds the residual up to a Magic7 value and holds the result item.
`timescale 1ns / 1ps

module m7aa_final #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = FRAC_BITS + 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [VW-1:0]               i_v,
    input  logic [VW-1:0]               i_acc,
    output logic                        o_valid,
    output logic [m7aa_pkg::ADJ_W-1:0]  o_adj
);
    import m7aa_pkg::*;

    localparam logic [VW-1:0] SEVENTH = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] ONE_U   = SEVENTH * VW'(7);
    localparam logic [VW-1:0] SIX_S   = SEVENTH * VW'(6);
    localparam logic [VW-1:0] LOW_M   = SEVENTH - VW'(1);
    localparam int            XW      = VW > ADJ_W ? VW : ADJ_W;

    logic [VW-1:0]    up;
    logic [VW-1:0]    sum;
    logic [XW-1:0]    sum_x;
    logic [ADJ_W-1:0] n_adj;
    logic             r_valid;
    logic [ADJ_W-1:0] r_adj;

    always_comb begin
        if (i_v == '0) begin
            up = '0;
        end else if (i_v < SEVENTH) begin
            up = VW'(pow2_ceil(t_word'(i_v)));
        end else if (i_v <= SIX_S) begin
            if ((i_v & LOW_M) == '0) begin
                up = i_v;
            end else begin
                up = (i_v & ~LOW_M) + SEVENTH;
            end
        end else begin
            up = ONE_U - VW'(pow2_floor(t_word'(ONE_U - i_v)));
        end
        sum   = i_acc + up;
        sum_x = XW'(sum);
        n_adj = sum_x[ADJ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adj <= n_adj;
        end
    end

    assign o_valid = r_valid;
    assign o_adj   = r_adj;

endmodule
